FILE: rtl/mlfd_pkg.sv
// Shared types and constants of the M-Bus long frame deframer.
package mlfd_pkg;

  localparam logic [7:0] FRAME_START = 8'h68;
  localparam logic [7:0] FRAME_STOP  = 8'h16;

  // Parser modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_SKIP  = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_START    = 3'd1,
    ST_LEN_MISMATCH = 3'd2,
    ST_LEN_SMALL    = 3'd3,
    ST_INCOMPLETE   = 3'd4,
    ST_BAD_STOP     = 3'd5,
    ST_CHECKSUM     = 3'd6,
    ST_NO_PAYLOAD   = 3'd7
  } status_e;

  localparam int unsigned POS_W   = 9;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LEN_MIN = 5;
  localparam int unsigned PAYLOAD_POS = 9;

  // Outcome of one parser step.
  typedef struct packed {
    logic               valid;
    logic [7:0]         payload;
    logic               is_final;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

FILE: rtl/mlfd_parser.sv
// Frame parser state and per-byte update of the M-Bus long frame deframer.
module mlfd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              skip_checksum_i,
  output mlfd_pkg::result_t result_o
);
  import mlfd_pkg::*;

  logic [1:0]         mode_q, mode_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         len_q, len_d;
  logic [7:0]         sum_q, sum_d;
  logic               match_q, match_d;
  status_e            status_q, status_d;
  logic [COUNT_W-1:0] total_q, total_d;

  logic [POS_W-1:0] lim;
  logic             have_payload;
  status_e          fin_status;

  assign lim = POS_W'(4) + POS_W'(len_q);

  always_comb begin
    mode_d       = mode_q;
    pos_d        = pos_q;
    len_d        = len_q;
    sum_d        = sum_q;
    match_d      = match_q;
    status_d     = status_q;
    total_d      = total_q;
    have_payload = 1'b0;
    fin_status   = status_q;
    result_o     = '0;

    case (mode_q)
      MODE_IDLE: begin
        if (byte_i == FRAME_START) begin
          mode_d  = MODE_FRAME;
          pos_d   = POS_W'(1);
          sum_d   = '0;
          match_d = 1'b0;
        end else begin
          mode_d = MODE_SKIP;
        end
      end
      MODE_FRAME: begin
        if (pos_q == POS_W'(1)) begin
          len_d = byte_i;
        end else if (pos_q == POS_W'(2)) begin
          // The second length byte is parked in the sum register.
          sum_d = byte_i;
        end else if (pos_q == POS_W'(3)) begin
          if (byte_i != FRAME_START) begin
            mode_d   = MODE_ERROR;
            status_d = ST_BAD_START;
          end else if (sum_q != len_q) begin
            mode_d   = MODE_ERROR;
            status_d = ST_LEN_MISMATCH;
          end else if (len_q < 8'(LEN_MIN)) begin
            mode_d   = MODE_ERROR;
            status_d = ST_LEN_SMALL;
          end else begin
            sum_d = '0;
          end
        end else if (pos_q < lim) begin
          sum_d = sum_q + byte_i;
          if (pos_q >= POS_W'(PAYLOAD_POS)) begin
            have_payload = 1'b1;
            if (total_q != '1) begin
              total_d = total_q + COUNT_W'(1);
            end
          end
        end else if (pos_q == lim) begin
          match_d = (byte_i == sum_q);
        end else begin
          if (byte_i != FRAME_STOP) begin
            mode_d   = MODE_ERROR;
            status_d = ST_BAD_STOP;
          end else if (!skip_checksum_i && !match_q) begin
            mode_d   = MODE_ERROR;
            status_d = ST_CHECKSUM;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        if (mode_d == MODE_FRAME) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      default: ;
    endcase

    if (last_i) begin
      fin_status = status_d;
      if (mode_d == MODE_FRAME && pos_d >= POS_W'(4)) begin
        fin_status = ST_INCOMPLETE;
      end
      result_o.valid    = 1'b1;
      result_o.is_final = 1'b1;
      if (fin_status != ST_OK) begin
        result_o.status = fin_status;
      end else if (total_d == '0) begin
        result_o.status = ST_NO_PAYLOAD;
      end else begin
        result_o.status = ST_OK;
        result_o.count  = total_d;
      end
      // The buffer is closed, so everything returns to its reset value.
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      len_d    = '0;
      sum_d    = '0;
      match_d  = 1'b0;
      status_d = ST_OK;
      total_d  = '0;
    end else if (have_payload) begin
      result_o.valid   = 1'b1;
      result_o.payload = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      match_q  <= 1'b0;
      status_q <= ST_OK;
      total_q  <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      match_q  <= match_d;
      status_q <= status_d;
      total_q  <= total_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_FRAME) |-> (pos_q != '0) && (pos_q <= lim + POS_W'(1)))
    else $error("frame position outside the frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ERROR) |-> (status_q != ST_OK))
    else $error("error mode without a latched status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (mode_q == MODE_IDLE) && (total_q == '0))
    else $error("state not cleared after the last byte");

endmodule

FILE: rtl/mbus_long_frame_deframer_core.sv
// An accepted item yields its result, if any, through the input register and then the result register.
// Throughput: one item per cycle while not stalled; the only loop is the parser state update.
// Ready falls only while an item waits in the input register and the result register is stalled.
// Reset (rst_ni, asynchronous, active low) empties both registers, clears the parser state
// and sets skip_checksum to 0; no clearing pass is needed.
module mbus_long_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // skip_checksum
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [7:0] payload_byte, [10:8] status,
                                       // [26:11] payload_count, [31:27] zero
  output logic        m_axis_tuser     // is_final
);
  import mlfd_pkg::*;

  logic       skip_q;
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       res_v_q;
  result_t    res_q;
  result_t    step_res;
  logic       proc;

  // An item is processed once the result register is free or being emptied.
  assign proc          = in_v_q && (!res_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
    end else if (cfg_we_i) begin
      skip_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  mlfd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (proc),
    .byte_i          (in_byte_q),
    .last_i          (in_last_q),
    .skip_checksum_i (skip_q),
    .result_o        (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (proc) begin
      res_v_q <= step_res.valid;
    end else if (m_axis_tready) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && step_res.valid) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = {5'b0, res_q.count, res_q.status, res_q.payload};
  assign m_axis_tuser  = res_q.is_final;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && res_q.is_final) |-> (res_q.payload == '0)
      && ((res_q.status == ST_OK) || (res_q.count == '0)))
    else $error("final item carries payload or a count with an error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_q.is_final) |-> (res_q.status == ST_OK) && (res_q.count == '0))
    else $error("payload item carries status or count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !m_axis_tready) |=> res_v_q)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_v_q) |-> s_axis_tready)
    else $error("input stalled while the input register is empty");

endmodule

FILE: verif/tb_mbus_long_frame_deframer_core.sv
// Self-checking testbench for the M-Bus long frame deframer core.
module tb_mbus_long_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfd_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic [7:0]         payload;
    logic               is_final;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } deframed_t;

  typedef enum int unsigned {
    FAULT_NONE,
    FAULT_START,
    FAULT_LEN_DIFF,
    FAULT_LEN_SHORT,
    FAULT_STOP,
    FAULT_SUM,
    FAULT_STOP_SUM
  } frame_fault_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;    // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [7:0] payload_byte, [10:8] status,
                                        // [26:11] payload_count, [31:27] zero
  logic        m_axis_tuser;            // is_final

  mbus_long_frame_deframer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Parser mirror state.
  logic [1:0]         prs_mode;
  logic [POS_W-1:0]   prs_pos;
  logic [7:0]         prs_len;
  logic [7:0]         prs_sum;
  logic               prs_sum_ok;
  status_e            prs_status;
  logic [COUNT_W-1:0] prs_total;
  logic               prs_skip_sum;

  stream_byte_t pending_q[$];
  deframed_t    predicted_q[$];
  logic [7:0]   buf_q[$];

  logic         idle_on = 1'b1;
  int unsigned  hold_req_cnt  = 0;
  int unsigned  hold_done_cnt = 0;
  int unsigned  rx_hold_left  = 0;
  int unsigned  rx_wait_left  = 0;
  int unsigned  tx_gap_left   = 0;
  int unsigned  rx_draw;
  int unsigned  quiet_cycles  = 0;

  int unsigned  error_count   = 0;
  int unsigned  n_buffers     = 0;
  int unsigned  n_bytes_in    = 0;
  int unsigned  n_payload_out = 0;
  int unsigned  n_status_out  = 0;
  int unsigned  n_status_bad  = 0;

  stream_byte_t tx_next;
  deframed_t    rx_want;

  function automatic void clear_parser();
    prs_mode   = MODE_IDLE;
    prs_pos    = '0;
    prs_len    = '0;
    prs_sum    = '0;
    prs_sum_ok = 1'b0;
    prs_status = ST_OK;
    prs_total  = '0;
  endfunction

  function automatic void latch_error(input status_e code);
    prs_mode   = MODE_ERROR;
    prs_status = code;
  endfunction

  // Advances the parser mirror by one byte and queues the result it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    int unsigned p;
    int unsigned l;
    logic        emit;
    deframed_t   r;
    p    = prs_pos;
    l    = prs_len;
    emit = 1'b0;
    case (prs_mode)
      MODE_IDLE: begin
        if (b == FRAME_START) begin
          prs_mode   = MODE_FRAME;
          prs_pos    = POS_W'(1);
          prs_sum    = '0;
          prs_sum_ok = 1'b0;
        end else begin
          prs_mode = MODE_SKIP;
        end
      end
      MODE_FRAME: begin
        if (p == 1) begin
          prs_len = b;
        end else if (p == 2) begin
          // The second length byte is parked in the sum until the intro is checked.
          prs_sum = b;
        end else if (p == 3) begin
          if (b != FRAME_START) latch_error(ST_BAD_START);
          else if (prs_sum != l[7:0]) latch_error(ST_LEN_MISMATCH);
          else if (l < LEN_MIN) latch_error(ST_LEN_SMALL);
          else prs_sum = '0;
        end else if (p < 4 + l) begin
          prs_sum = prs_sum + b;
          if (p >= PAYLOAD_POS) begin
            emit = 1'b1;
            if (prs_total != '1) prs_total = prs_total + COUNT_W'(1);
          end
        end else if (p == 4 + l) begin
          prs_sum_ok = (b == prs_sum);
        end else begin
          if (b != FRAME_STOP) latch_error(ST_BAD_STOP);
          else if (!prs_skip_sum && !prs_sum_ok) latch_error(ST_CHECKSUM);
          else prs_mode = MODE_IDLE;
        end
        if (prs_mode == MODE_FRAME) prs_pos = prs_pos + POS_W'(1);
      end
      default: ;
    endcase

    if (last) begin
      if (prs_mode == MODE_FRAME && prs_pos >= POS_W'(4)) latch_error(ST_INCOMPLETE);
      r = '{8'h00, 1'b1, ST_OK, '0};
      if (prs_status != ST_OK) r.status = prs_status;
      else if (prs_total == '0) r.status = ST_NO_PAYLOAD;
      else r.count = prs_total;
      predicted_q.push_back(r);
      clear_parser();
    end else if (emit) begin
      predicted_q.push_back('{b, 1'b0, ST_OK, '0});
    end
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endfunction

  // Sender: one item at a time, with a random gap drawn per item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap_left   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        n_bytes_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left   <= tx_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          tx_next        = pending_q.pop_front();
          s_axis_tdata  <= tx_next.data;
          s_axis_tlast  <= tx_next.last;
          s_axis_tvalid <= 1'b1;
          tx_gap_left   <= idle_on ? $urandom_range(0, 4) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and drives ready with random stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser) begin
          n_status_out++;
          if (m_axis_tdata[10:8] != ST_OK) n_status_bad++;
        end else begin
          n_payload_out++;
        end
        if (predicted_q.size() == 0) begin
          note_mismatch("unexpected item", '0, m_axis_tdata);
        end else begin
          rx_want = predicted_q.pop_front();
          if (m_axis_tdata[7:0] != rx_want.payload)
            note_mismatch("payload_byte", rx_want.payload, m_axis_tdata[7:0]);
          if (m_axis_tdata[10:8] != rx_want.status)
            note_mismatch("status", rx_want.status, m_axis_tdata[10:8]);
          if (m_axis_tdata[26:11] != rx_want.count)
            note_mismatch("payload_count", rx_want.count, m_axis_tdata[26:11]);
          if (m_axis_tuser != rx_want.is_final)
            note_mismatch("is_final", rx_want.is_final, m_axis_tuser);
          if (m_axis_tdata[31:27] != '0)
            note_mismatch("padding", '0, m_axis_tdata[31:27]);
        end
      end

      if (hold_req_cnt != hold_done_cnt) begin
        rx_hold_left  <= HOLD_CYCLES;
        hold_done_cnt <= hold_done_cnt + 1;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left  <= rx_hold_left - 1;
        m_axis_tready <= (rx_hold_left == 1);
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_draw        = idle_on ? $urandom_range(0, 4) : 0;
        rx_wait_left  <= rx_draw;
        m_axis_tready <= (rx_draw == 0);
      end else if (rx_wait_left != 0) begin
        rx_wait_left  <= rx_wait_left - 1;
        m_axis_tready <= (rx_wait_left == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_skip_sum(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    prs_skip_sum = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic flush_buffer();
    for (int unsigned i = 0; i < buf_q.size(); i++)
      pending_q.push_back('{buf_q[i], (i == buf_q.size() - 1)});
    if (buf_q.size() != 0) n_buffers++;
    buf_q.delete();
  endtask

  task automatic add_frame(input int unsigned len_val, input frame_fault_e fault);
    logic [7:0] l;
    logic [7:0] l2;
    logic [7:0] sum;
    logic [7:0] b;
    l  = (fault == FAULT_LEN_SHORT) ? 8'($urandom_range(0, LEN_MIN - 1)) : 8'(len_val);
    l2 = (fault == FAULT_LEN_DIFF) ? l ^ (8'h01 << $urandom_range(0, 7)) : l;
    buf_q.push_back(FRAME_START);
    buf_q.push_back(l);
    buf_q.push_back(l2);
    b = 8'($urandom);
    if (b == FRAME_START) b = ~b;
    buf_q.push_back((fault == FAULT_START) ? b : FRAME_START);
    sum = '0;
    for (int unsigned i = 0; i < l; i++) begin
      b = 8'($urandom);
      buf_q.push_back(b);
      sum = sum + b;
    end
    if (fault == FAULT_SUM || fault == FAULT_STOP_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    buf_q.push_back(sum);
    b = 8'($urandom);
    if (b == FRAME_STOP) b = ~b;
    buf_q.push_back((fault == FAULT_STOP || fault == FAULT_STOP_SUM) ? b : FRAME_STOP);
  endtask

  // Mostly well-formed buffers of a few frames, some with a fault, a cut or a noisy tail.
  task automatic run_random(input int unsigned n_target, input int unsigned hold_at);
    int unsigned  queued;
    int unsigned  n_frames;
    int unsigned  len_val;
    int unsigned  cut;
    frame_fault_e fault;
    logic         held;
    queued = 0;
    held   = 1'b0;
    while (queued < n_target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) buf_q.push_back(8'($urandom));
      end else begin
        n_frames = $urandom_range(1, 3);
        repeat (n_frames) begin
          len_val = ($urandom_range(0, 15) == 0) ? $urandom_range(LEN_MIN, 255)
                                                 : $urandom_range(LEN_MIN, 16);
          fault = ($urandom_range(0, 4) == 0) ? frame_fault_e'($urandom_range(1, 6))
                                              : FAULT_NONE;
          add_frame(len_val, fault);
        end
        case ($urandom_range(0, 5))
          0: begin
            cut = $urandom_range(1, buf_q.size() - 1);
            while (buf_q.size() > cut) buf_q.delete(buf_q.size() - 1);
          end
          1: repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom));
          default: ;
        endcase
      end
      queued += buf_q.size();
      flush_buffer();
      // The receiver holds off while the sender keeps going, so the core backs up.
      if (!held && queued >= hold_at) begin
        held = 1'b1;
        hold_req_cnt++;
      end
      while (pending_q.size() > 32) @(negedge clk_i);
    end
  endtask

  initial begin
    clear_parser();
    prs_skip_sum = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_skip_sum(1'b0);

    // Good frame whose payload holds both extreme byte values.
    buf_q = {8'h68, 8'h07, 8'h07, 8'h68, 8'h53, 8'hFE, 8'h51, 8'h01, 8'h02,
             8'h00, 8'hFF, 8'hA4, 8'h16};
    flush_buffer();
    // Bad second start together with a length mismatch: the bad start must win.
    buf_q = {8'h68, 8'h05, 8'h06, 8'h00};
    flush_buffer();
    // Length below the minimum header size.
    buf_q = {8'h68, 8'h04, 8'h04, 8'h68};
    flush_buffer();
    // Intro cut short, and a buffer of nothing but garbage.
    buf_q = {8'h68, 8'h05};
    flush_buffer();
    buf_q = {8'h42};
    flush_buffer();
    wait_drained();

    run_random(380, 1000);
    wait_drained();
    write_skip_sum(1'b1);
    run_random(380, 200);
    wait_drained();

    write_skip_sum(1'b0);
    idle_on = 1'b1;
    run_random(150, 1000);
    wait_drained();

    if (predicted_q.size() != 0)
      note_mismatch("missing items", predicted_q.size(), '0);

    $display("Ran %0d buffers (%0d bytes) through the deframer, skip_checksum both ways.",
             n_buffers, n_bytes_in);
    $display("Checked %0d payload bytes and %0d status items, %0d of them errors.",
             n_payload_out, n_status_out, n_status_bad);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
